### rtl/tea_pkg.sv
`timescale 1ns / 1ps

package tea_pkg;

  localparam logic [31:0] TEA_DELTA = 32'h9E37_79B9;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned KEY_WORDS = 4;
  localparam int unsigned KEY_IDX_W = $clog2(KEY_WORDS);

  typedef enum logic [KEY_IDX_W-1:0] {
    KEY_IDX_0 = 2'd0,
    KEY_IDX_1 = 2'd1,
    KEY_IDX_2 = 2'd2,
    KEY_IDX_3 = 2'd3
  } key_idx_t;

  typedef enum logic {
    KIND_ENCRYPT = 1'b0,
    KIND_DECRYPT = 1'b1
  } kind_t;

  typedef struct packed {
    logic [WORD_W-1:0] k0;
    logic [WORD_W-1:0] k1;
    logic [WORD_W-1:0] k2;
    logic [WORD_W-1:0] k3;
  } key_t;

  // One word in flight through the cell chain.
  typedef struct packed {
    logic              valid;
    kind_t             kind;
    logic [WORD_W-1:0] v0;
    logic [WORD_W-1:0] v1;
    logic [WORD_W-1:0] sum;
  } cell_word_t;

endpackage

### rtl/tea_cell.sv
`timescale 1ns / 1ps

// One half-round of TEA. Even cells own the first half of a round, odd cells
// the second half and the sum step.
module tea_cell #(
  parameter bit SECOND_HALF = 1'b0
) (
  input  logic                clk,
  input  logic                rst_n,
  input  tea_pkg::key_t       key,
  input  tea_pkg::cell_word_t word_in,
  output tea_pkg::cell_word_t word_out
);

  tea_pkg::cell_word_t word_r;
  tea_pkg::cell_word_t word_nxt;

  logic        upd_v0;
  logic [31:0] x;
  logic [31:0] ka;
  logic [31:0] kb;
  logic [31:0] mix;
  logic [31:0] tgt;
  logic [31:0] tgt_new;

  // Encrypt updates v0 first, decrypt updates v1 first.
  assign upd_v0 = ((word_in.kind == tea_pkg::KIND_DECRYPT) == SECOND_HALF);

  always_comb begin
    x   = upd_v0 ? word_in.v1 : word_in.v0;
    ka  = upd_v0 ? key.k0 : key.k2;
    kb  = upd_v0 ? key.k1 : key.k3;
    tgt = upd_v0 ? word_in.v0 : word_in.v1;
    mix = ((x << 4) + ka) ^ (x + word_in.sum) ^ ((x >> 5) + kb);
    tgt_new = (word_in.kind == tea_pkg::KIND_DECRYPT) ? (tgt - mix) : (tgt + mix);
  end

  always_comb begin
    word_nxt       = word_in;
    word_nxt.v0    = upd_v0 ? tgt_new : word_in.v0;
    word_nxt.v1    = upd_v0 ? word_in.v1 : tgt_new;
    if (SECOND_HALF) begin
      word_nxt.sum = (word_in.kind == tea_pkg::KIND_DECRYPT) ?
                     (word_in.sum - tea_pkg::TEA_DELTA) :
                     (word_in.sum + tea_pkg::TEA_DELTA);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      word_r <= '0;
    end else begin
      word_r <= word_nxt;
    end
  end

  assign word_out = word_r;

`ifndef SYNTHESIS
  a_valid_advance: assert property (@(posedge clk) disable iff (!rst_n)
    word_in.valid |=> word_r.valid)
    else $error("tea_cell: valid word dropped");

  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    !word_in.valid |=> !word_r.valid)
    else $error("tea_cell: word appeared from nothing");

  a_other_half_held: assert property (@(posedge clk) disable iff (!rst_n)
    word_in.valid |=> ($past(upd_v0) ? (word_r.v1 == $past(word_in.v1))
                                     : (word_r.v0 == $past(word_in.v0))))
    else $error("tea_cell: untouched half changed");

  a_sum_step: assert property (@(posedge clk) disable iff (!rst_n)
    (word_in.valid && SECOND_HALF) |=>
      ((word_r.kind == tea_pkg::KIND_DECRYPT) ?
        (word_r.sum == $past(word_in.sum) - tea_pkg::TEA_DELTA) :
        (word_r.sum == $past(word_in.sum) + tea_pkg::TEA_DELTA)))
    else $error("tea_cell: sum stepped wrong");
`endif

endmodule

### rtl/tea_block_cipher_top.sv
`timescale 1ns / 1ps

// TEA block cipher, fully pipelined. Pulse start with in_kind (0 encrypt,
// 1 decrypt) and the two halves of a 64-bit block; a word is taken at every
// clock edge where start is high and busy is low. busy never rises, so one
// block can enter every cycle. The processed block appears on
// out_first_word/out_second_word with out_valid high for exactly one cycle;
// the receiver must take it then, there is no hold-off. The block passes
// through a chain of 2*ROUNDS half-round cells, one register each. The
// 128-bit key lives in four registers written through
// cfg_we/cfg_index/cfg_wdata; change the key only while no block is in
// flight.
module tea_block_cipher_top #(
  parameter int unsigned ROUNDS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_wdata,
  // input word
  input  logic        start,
  output logic        busy,
  input  logic        in_kind,
  input  logic [31:0] in_first_word,
  input  logic [31:0] in_second_word,
  // result word
  output logic        out_valid,
  output logic [31:0] out_first_word,
  output logic [31:0] out_second_word
);

  localparam int unsigned NUM_CELLS = 2 * ROUNDS;
  // Decrypt starts from the sum that the last encryption round uses.
  localparam logic [31:0] DEC_SUM_INIT = 32'(tea_pkg::TEA_DELTA * ROUNDS);

  tea_pkg::key_t       key_r;
  tea_pkg::cell_word_t chain [NUM_CELLS+1];
  logic                in_accept;

  // The pipeline never stalls, so busy holds low.
  assign busy      = 1'b0;
  assign in_accept = start && !busy;

  // Key registers; write only while idle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r <= '0;
    end else if (cfg_we) begin
      unique case (tea_pkg::key_idx_t'(cfg_index))
        tea_pkg::KEY_IDX_0: key_r.k0 <= cfg_wdata;
        tea_pkg::KEY_IDX_1: key_r.k1 <= cfg_wdata;
        tea_pkg::KEY_IDX_2: key_r.k2 <= cfg_wdata;
        tea_pkg::KEY_IDX_3: key_r.k3 <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Seed the chain: encryption enters with the sum of its first round, decryption with DEC_SUM_INIT.
  assign chain[0] = '{valid: in_accept,
                      kind:  tea_pkg::kind_t'(in_kind),
                      v0:    in_first_word,
                      v1:    in_second_word,
                      sum:   (in_kind ? DEC_SUM_INIT : tea_pkg::TEA_DELTA)};

  // Advance one half-round per cell per cycle.
  for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
    tea_cell #(
      .SECOND_HALF(1'((g % 2) != 0))
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .key      (key_r),
      .word_in  (chain[g]),
      .word_out (chain[g+1])
    );
  end

  assign out_valid       = chain[NUM_CELLS].valid;
  assign out_first_word  = chain[NUM_CELLS].v0;
  assign out_second_word = chain[NUM_CELLS].v1;

`ifndef SYNTHESIS
  a_busy_low: assert property (@(posedge clk) disable iff (!rst_n)
    !busy)
    else $error("tea top: busy raised");

  a_fixed_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |-> ##NUM_CELLS out_valid)
    else $error("tea top: block not out on time");

  a_enc_final_sum: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && chain[NUM_CELLS].kind == tea_pkg::KIND_ENCRYPT) |->
      (chain[NUM_CELLS].sum == DEC_SUM_INIT + tea_pkg::TEA_DELTA))
    else $error("tea top: encrypt sum out of step");

  a_dec_final_sum: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && chain[NUM_CELLS].kind == tea_pkg::KIND_DECRYPT) |->
      (chain[NUM_CELLS].sum == 32'h0000_0000))
    else $error("tea top: decrypt sum out of step");
`endif

endmodule
